/* sv/srs_pkg.sv */
// Shared constants, types and codes of the selective-repeat sender.
package srs_pkg;

  localparam int unsigned ChunkSlots = 16;
  localparam int unsigned IdxW       = (ChunkSlots > 1) ? $clog2(ChunkSlots) : 1;
  localparam int unsigned CntW       = 5;
  localparam int unsigned KindW      = 3;
  localparam int unsigned RoundW     = 10;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned AckIdW     = 16;

  localparam logic [TimeW-1:0]  DefTimeout = 32'd100000;
  localparam logic [RoundW-1:0] DefRounds  = 10'd100;
  localparam logic [RoundW-1:0] RoundMax   = 10'd1023;

  // register indexes on the config port
  localparam logic RegTimeout = 1'b0;
  localparam logic RegRounds  = 1'b1;

  // input operation codes
  localparam logic OpStart = 1'b0;
  localparam logic OpPoll  = 1'b1;

  typedef enum logic [KindW-1:0] {
    KSend    = 3'd0,
    KResend  = 3'd1,
    KPending = 3'd2,
    KDone    = 3'd3,
    KGaveUp  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StSend,
    StAck,
    StScan,
    StStat
  } state_e;

  typedef struct packed {
    logic [TimeW-1:0]  timeout;
    logic [RoundW-1:0] max_rounds;
  } cfg_t;

  typedef struct packed {
    logic              operation;
    logic [CntW-1:0]   chunk_count;
    logic              ack_valid;
    logic [AckIdW-1:0] ack_id;
    logic [TimeW-1:0]  time_now;
  } item_t;

  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [CntW-1:0] chunk_id;
    logic [CntW-1:0] total;
    logic            last;
  } res_t;

endpackage

/* sv/selective_repeat_sender_top.sv */
// Top level of the selective-repeat sender: config registers and sequencer.
// Usage:
//   Items enter on start with busy low; the item fields are sampled at that
//   edge. operation_i = 0 opens a message of chunk_count_i chunks (capped at
//   16) stamped with time_now_i and emits one send word per chunk.
//   operation_i = 1 runs a poll round: the ack is applied, each unacked
//   chunk whose age reaches timeout_ticks gets a resend word and a new stamp,
//   then one status word closes the round (pending, all acked, gave up).
//   Every word is on the result ports for one cycle with res_strobe_o high;
//   last_o marks the final word of an item. The receiver cannot stall.
// Sequence:
//   start item: one send word per cycle, one per chunk in chunk order.
//   poll item: ack update, then each chunk in turn through the
//   shared age compare (stamp memory read one entry ahead), then the status word.
//   Status-only items (empty start, poll while idle transfer) go straight to the status word.
//   Each word is made in a sequencer state and then registered onto the result ports.
// Config: APB, word at 0x0 = timeout_ticks (reset 100000), 0x4 = max_rounds
//   (10 bit, reset 100). Write only while busy is low and no word pending.
// Reset clears the ack map, counters and the transfer; stamps stay stale.
module selective_repeat_sender_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation_i,
  input  logic [srs_pkg::CntW-1:0]   chunk_count_i,
  input  logic                       ack_valid_i,
  input  logic [srs_pkg::AckIdW-1:0] ack_id_i,
  input  logic [srs_pkg::TimeW-1:0]  time_now_i,
  // result channel
  output logic                       res_strobe_o,
  output logic [srs_pkg::KindW-1:0]  kind_o,
  output logic [srs_pkg::CntW-1:0]   chunk_id_o,
  output logic [srs_pkg::CntW-1:0]   total_o,
  output logic                       last_o,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import srs_pkg::*;

  cfg_t  cfg_q, cfg_d;
  item_t item;
  res_t  res;
  logic  cfg_wr;
  logic  reg_sel;

  // word-addressed: bit 2 picks the register, low bits ignored
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        RegTimeout: cfg_d.timeout    = pwdata;
        RegRounds:  cfg_d.max_rounds = pwdata[RoundW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout    <= DefTimeout;
      cfg_q.max_rounds <= DefRounds;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegTimeout: prdata = cfg_q.timeout;
      RegRounds:  prdata = {{(32-RoundW){1'b0}}, cfg_q.max_rounds};
      default:    prdata = '0;
    endcase
  end

  assign item.operation   = operation_i;
  assign item.chunk_count = chunk_count_i;
  assign item.ack_valid   = ack_valid_i;
  assign item.ack_id      = ack_id_i;
  assign item.time_now    = time_now_i;

  srs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .item_i (item),
    .cfg_i  (cfg_q),
    .busy_o (busy),
    .res_o  (res)
  );

  assign res_strobe_o = res.valid;
  assign kind_o       = res.kind;
  assign chunk_id_o   = res.chunk_id;
  assign total_o      = res.total;
  assign last_o       = res.last;

endmodule

/* sv/srs_age_unit.sv */
// Shared age check: wrapping subtract of a stamp from the current time, then compare.
module srs_age_unit (
  input  logic [srs_pkg::TimeW-1:0] now_i,
  input  logic [srs_pkg::TimeW-1:0] stamp_i,
  input  logic [srs_pkg::TimeW-1:0] timeout_i,
  output logic                      expired_o
);
  import srs_pkg::*;

  logic [TimeW-1:0] age;

  assign age       = now_i - stamp_i;  // modulo 2^32
  assign expired_o = (age >= timeout_i);

endmodule

/* sv/srs_ctrl.sv */
// Sequencer of the sender: send loop, ack update, chunk scan and status word.
module srs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  srs_pkg::item_t item_i,
  input  srs_pkg::cfg_t  cfg_i,
  output logic           busy_o,
  output srs_pkg::res_t  res_o
);
  import srs_pkg::*;

  state_e state_q, state_d;

  logic [CntW-1:0]       msg_q, msg_d;
  logic [RoundW-1:0]     rc_q, rc_d;
  logic                  active_q, active_d;
  logic                  done_flag_q, done_flag_d;   // last final status was "all acked"
  logic                  poll_active_q, poll_active_d;
  kind_e                 stat_kind_q, stat_kind_d;
  logic [ChunkSlots-1:0] acked_q, acked_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       acked_cnt_q, acked_cnt_d;
  logic [TimeW-1:0]      now_q, now_d;
  logic                  ackv_q, ackv_d;
  logic [AckIdW-1:0]     ackid_q, ackid_d;
  res_t                  res_q, res_d;

  // stamp memory
  logic [TimeW-1:0] stamp_mem [ChunkSlots];
  logic [TimeW-1:0] rd_q;
  logic [IdxW-1:0]  rd_addr;
  logic             wr_en;

  logic            accept;
  logic [CntW-1:0] sat_cnt;
  logic [CntW-1:0] idx_next;
  logic            idx_is_last;
  logic            expired;
  logic            ack_ok;
  kind_e           final_kind;

  assign accept      = start_i && (state_q == StIdle);
  assign sat_cnt     = (item_i.chunk_count > CntW'(ChunkSlots)) ? CntW'(ChunkSlots)
                                                               : item_i.chunk_count;
  assign idx_next    = CntW'(idx_q) + CntW'(1);
  assign idx_is_last = (idx_next == msg_q);
  assign ack_ok      = ackv_q && (ackid_q != '0) && (ackid_q <= AckIdW'(msg_q));

  srs_age_unit u_age (
    .now_i     (now_q),
    .stamp_i   (rd_q),
    .timeout_i (cfg_i.timeout),
    .expired_o (expired)
  );

  always_comb begin
    if (acked_cnt_q == msg_q) begin
      final_kind = KDone;
    end else if (rc_q >= cfg_i.max_rounds) begin
      final_kind = KGaveUp;
    end else begin
      final_kind = KPending;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (item_i.operation == OpStart) begin
            state_d = (sat_cnt == '0) ? StStat : StSend;
          end else begin
            state_d = active_q ? StAck : StStat;
          end
        end
      end
      StSend: if (idx_is_last) state_d = StIdle;
      StAck:  state_d = StScan;
      StScan: if (idx_is_last) state_d = StStat;
      StStat: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs: result word, memory port
  always_comb begin
    res_d          = '0;
    res_d.kind     = KSend;
    res_d.total    = msg_q;
    wr_en          = 1'b0;
    rd_addr        = '0;
    unique case (state_q)
      StSend: begin
        res_d.valid    = 1'b1;
        res_d.kind     = KSend;
        res_d.chunk_id = idx_next;
        res_d.last     = idx_is_last;
        wr_en          = 1'b1;
      end
      StScan: begin
        rd_addr = idx_q + IdxW'(1);
        if (!acked_q[idx_q] && expired) begin
          res_d.valid    = 1'b1;
          res_d.kind     = KResend;
          res_d.chunk_id = idx_next;
          wr_en          = 1'b1;
        end
      end
      StStat: begin
        res_d.valid = 1'b1;
        res_d.kind  = poll_active_q ? final_kind : stat_kind_q;
        res_d.last  = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    msg_d         = msg_q;
    rc_d          = rc_q;
    active_d      = active_q;
    done_flag_d   = done_flag_q;
    poll_active_d = poll_active_q;
    stat_kind_d   = stat_kind_q;
    acked_d       = acked_q;
    idx_d         = idx_q;
    acked_cnt_d   = acked_cnt_q;
    now_d         = now_q;
    ackv_d        = ackv_q;
    ackid_d       = ackid_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          now_d   = item_i.time_now;
          ackv_d  = item_i.ack_valid;
          ackid_d = item_i.ack_id;
          idx_d   = '0;
          if (item_i.operation == OpStart) begin
            msg_d         = sat_cnt;
            rc_d          = '0;
            acked_d       = '0;
            poll_active_d = 1'b0;
            stat_kind_d   = KDone;
            if (sat_cnt == '0) begin
              active_d    = 1'b0;
              done_flag_d = 1'b1;
            end else begin
              active_d = 1'b1;
            end
          end else begin
            poll_active_d = active_q;
            stat_kind_d   = done_flag_q ? KDone : KGaveUp;
          end
        end
      end
      StSend: idx_d = idx_q + IdxW'(1);
      StAck: begin
        if (ack_ok) acked_d[IdxW'(ackid_q - AckIdW'(1))] = 1'b1;
        if (rc_q < RoundMax) rc_d = rc_q + RoundW'(1);
        idx_d       = '0;
        acked_cnt_d = '0;
      end
      StScan: begin
        if (acked_q[idx_q]) acked_cnt_d = acked_cnt_q + CntW'(1);
        idx_d = idx_q + IdxW'(1);
      end
      StStat: begin
        if (poll_active_q && (final_kind != KPending)) begin
          active_d    = 1'b0;
          done_flag_d = (final_kind == KDone);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      msg_q         <= '0;
      rc_q          <= '0;
      active_q      <= 1'b0;
      done_flag_q   <= 1'b1;
      poll_active_q <= 1'b0;
      stat_kind_q   <= KDone;
      acked_q       <= '0;
      idx_q         <= '0;
      acked_cnt_q   <= '0;
      res_q         <= '0;
    end else begin
      state_q       <= state_d;
      msg_q         <= msg_d;
      rc_q          <= rc_d;
      active_q      <= active_d;
      done_flag_q   <= done_flag_d;
      poll_active_q <= poll_active_d;
      stat_kind_q   <= stat_kind_d;
      acked_q       <= acked_d;
      idx_q         <= idx_d;
      acked_cnt_q   <= acked_cnt_d;
      res_q         <= res_d;
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    ackv_q  <= ackv_d;
    ackid_q <= ackid_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) stamp_mem[idx_q] <= now_q;
    rd_q <= stamp_mem[rd_addr];
  end

  assign busy_o = (state_q != StIdle);
  assign res_o  = res_q;

endmodule

/* sv/srs_checker.sv */
// Port-level checks of the sender, bound to the top level.
module srs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      res_strobe_o,
  input logic [srs_pkg::KindW-1:0] kind_o,
  input logic [srs_pkg::CntW-1:0]  chunk_id_o,
  input logic [srs_pkg::CntW-1:0]  total_o,
  input logic                      last_o
);
  import srs_pkg::*;

  // an accepted item always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accept did not raise busy");

  // words come only out of a busy cycle
  a_word_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy))
    else $error("result word without work in flight");

  // the closing word coincides with the return to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (res_strobe_o && last_o))
    else $error("busy dropped without a closing word");

  // send and resend ids lie within the message
  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && ((kind_o == KSend) || (kind_o == KResend)))
      |-> ((chunk_id_o != '0) && (chunk_id_o <= total_o)))
    else $error("chunk id out of range");

endmodule

bind selective_repeat_sender_top srs_checker u_srs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .kind_o       (kind_o),
  .chunk_id_o   (chunk_id_o),
  .total_o      (total_o),
  .last_o       (last_o)
);
